[hdl/rhp_pkg.sv]
// Shared types and constants for the RGB to HSV pixel converter.
package rhp_pkg;

  localparam int HUE_W     = 15;
  localparam int SAT_W     = 8;
  localparam int HUE_SECTOR = 3840;   // 60 degrees in 1/64 degree units
  localparam int HUE_OFS_G = 7680;    // 120 degrees
  localparam int HUE_OFS_B = 15360;   // 240 degrees
  localparam int HUE_FULL  = 23040;   // 360 degrees
  localparam int HUE_LIMIT = 23039;
  localparam int SAT_LIMIT = 255;
  localparam int SAT_SHIFT = 8;       // saturation is a fraction of 256
  localparam int HUE_QB    = 12;      // hue quotient bits, quotient <= 3840
  localparam int SAT_QB    = 9;       // saturation quotient bits, quotient <= 256

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  typedef struct packed {
    sector_e sector;  // channel holding the maximum
    logic    neg;     // hue difference is negative
    logic    flat;    // black or grey pixel: hue and saturation forced to zero
  } cls_t;

endpackage

[hdl/rgb_to_hsv_pixel.sv]
// Top level of the RGB to HSV pixel converter.
// One pixel in per clock and one result out per clock, sustained while the
// output side does not stall. A pixel is classified on arrival (max, min, hue
// sector), parked in a two-entry queue, then passes a load register, a
// 12-stage pipeline that works out one quotient bit per stage for hue and
// saturation at once (the saturation division ending after its 9 bits), and
// an output register. Stalling the output holds the whole divider pipe and,
// once the queue fills, the input. Hue is in 1/64 degree (0..23039),
// saturation a fraction of 256 clamped to 255, brightness the largest
// channel. Black and grey pixels give zero hue and saturation.
module rgb_to_hsv_pixel import rhp_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [HUE_W-1:0]        hue_o,
  output logic [SAT_W-1:0]        saturation_o,
  output logic [CHANNEL_BITS-1:0] brightness_o
);

  localparam int CB = CHANNEL_BITS;
  localparam int QW = $bits(cls_t) + 3 * CB;

  cls_t          f_cls, b_cls;
  logic [CB-1:0] f_hi, f_diff, f_mag;
  logic [CB-1:0] b_hi, b_diff, b_mag;
  logic [QW-1:0] q_wdata, q_rdata;
  logic          q_valid, q_ready;

  rhp_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .red_i  (red_i),
    .green_i(green_i),
    .blue_i (blue_i),
    .cls_o  (f_cls),
    .hi_o   (f_hi),
    .diff_o (f_diff),
    .mag_o  (f_mag)
  );

  assign q_wdata = {f_cls, f_hi, f_diff, f_mag};

  rhp_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(in_valid_i),
    .push_ready_o(in_ready_o),
    .push_data_i (q_wdata),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_rdata)
  );

  assign {b_cls, b_hi, b_diff, b_mag} = q_rdata;

  rhp_back #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_cls_i    (b_cls),
    .in_hi_i     (b_hi),
    .in_diff_i   (b_diff),
    .in_mag_i    (b_mag),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .brightness_o(brightness_o)
  );

endmodule

[hdl/rhp_front.sv]
// Front end: finds max, min and hue sector of one pixel.
module rhp_front import rhp_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output cls_t                    cls_o,
  output logic [CHANNEL_BITS-1:0] hi_o,
  output logic [CHANNEL_BITS-1:0] diff_o,
  output logic [CHANNEL_BITS-1:0] mag_o
);

  logic [CHANNEL_BITS-1:0]        hi;
  logic [CHANNEL_BITS-1:0]        lo;
  logic signed [CHANNEL_BITS:0]   num;
  logic signed [CHANNEL_BITS:0]   abs_num;
  sector_e                        sector;

  always_comb begin
    hi = red_i;
    lo = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi)  hi = blue_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo)  lo = blue_i;

    // ties go to red, then green
    if (hi == red_i) begin
      sector = SECT_RED;
      num    = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (hi == green_i) begin
      sector = SECT_GREEN;
      num    = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sector = SECT_BLUE;
      num    = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    abs_num = num[CHANNEL_BITS] ? -num : num;
  end

  assign hi_o        = hi;
  assign diff_o      = hi - lo;
  assign mag_o       = abs_num[CHANNEL_BITS-1:0];
  assign cls_o.sector = sector;
  assign cls_o.neg    = num[CHANNEL_BITS];
  assign cls_o.flat   = (hi == '0) || (hi == lo);

endmodule

[hdl/rhp_queue.sv]
// Two-entry queue between the front end and the divider pipeline.
module rhp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

[hdl/rhp_back.sv]
// Back end: pipelined restoring dividers for hue and saturation, then final fix-up.
module rhp_back import rhp_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  cls_t                    in_cls_i,
  input  logic [CHANNEL_BITS-1:0] in_hi_i,
  input  logic [CHANNEL_BITS-1:0] in_diff_i,
  input  logic [CHANNEL_BITS-1:0] in_mag_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [HUE_W-1:0]        hue_o,
  output logic [SAT_W-1:0]        saturation_o,
  output logic [CHANNEL_BITS-1:0] brightness_o
);

  localparam int CB   = CHANNEL_BITS;
  localparam int RW_H = CB + HUE_QB;     // holds mag * 3840
  localparam int RW_S = CB + SAT_QB;     // holds diff * 256
  localparam int NSTG = HUE_QB;

  logic                en;
  logic                v_q    [NSTG+1];
  cls_t                cls_q  [NSTG+1];
  logic [CB-1:0]       hi_q   [NSTG+1];
  logic [CB-1:0]       diff_q [NSTG+1];
  logic [RW_H-1:0]     rem_h_q[NSTG+1];
  logic [HUE_QB-1:0]   hq_q   [NSTG+1];
  logic [RW_S-1:0]     rem_s_q[NSTG+1];
  logic [SAT_QB-1:0]   sq_q   [NSTG+1];

  logic                out_valid_q;
  logic [HUE_W-1:0]    hue_q, hue_d;
  logic [SAT_W-1:0]    sat_q, sat_d;
  logic [CB-1:0]       bright_q;

  // whole pipe moves unless the output register holds an untaken beat
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 0: load operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cls_q[0]   <= in_cls_i;
      hi_q[0]    <= in_hi_i;
      diff_q[0]  <= in_diff_i;
      rem_h_q[0] <= RW_H'(in_mag_i) * RW_H'(HUE_SECTOR);
      hq_q[0]    <= '0;
      rem_s_q[0] <= RW_S'(in_diff_i) << SAT_SHIFT;
      sq_q[0]    <= '0;
    end
  end

  // one quotient bit of the hue division per stage, and of saturation up to SAT_QB
  for (genvar s = 1; s <= NSTG; s++) begin : g_stage
    localparam int HB = HUE_QB - s;
    logic [RW_H-1:0] trial_h;
    logic            take_h;

    assign trial_h = RW_H'(diff_q[s-1]) << HB;
    assign take_h  = rem_h_q[s-1] >= trial_h;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cls_q[s]   <= cls_q[s-1];
        hi_q[s]    <= hi_q[s-1];
        diff_q[s]  <= diff_q[s-1];
        rem_h_q[s] <= take_h ? rem_h_q[s-1] - trial_h : rem_h_q[s-1];
        hq_q[s]    <= {hq_q[s-1][HUE_QB-2:0], take_h};
      end
    end

    if (s <= SAT_QB) begin : g_sat
      localparam int SB = SAT_QB - s;
      logic [RW_S-1:0] trial_s;
      logic            take_s;

      assign trial_s = RW_S'(hi_q[s-1]) << SB;
      assign take_s  = rem_s_q[s-1] >= trial_s;

      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_s_q[s] <= take_s ? rem_s_q[s-1] - trial_s : rem_s_q[s-1];
          sq_q[s]    <= {sq_q[s-1][SAT_QB-2:0], take_s};
        end
      end
    end else begin : g_sat_pass
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_s_q[s] <= rem_s_q[s-1];
          sq_q[s]    <= sq_q[s-1];
        end
      end
    end
  end

  // sector offset, wrap of negative hue, clamps and zeroing of flat pixels
  always_comb begin
    logic signed [16:0] ofs;
    logic signed [16:0] qs;
    logic signed [16:0] hs;
    case (cls_q[NSTG].sector)
      SECT_RED:   ofs = 17'sd0;
      SECT_GREEN: ofs = 17'(HUE_OFS_G);
      SECT_BLUE:  ofs = 17'(HUE_OFS_B);
      default:    ofs = 17'sd0;
    endcase
    qs = $signed({5'b0, hq_q[NSTG]});
    if (cls_q[NSTG].neg) qs = -qs;
    hs = ofs + qs;
    if (hs < 0) hs = hs + 17'(HUE_FULL);
    if (hs > 17'(HUE_LIMIT)) hs = 17'(HUE_LIMIT);
    if (hs < 0) hs = 17'sd0;

    hue_d = hs[HUE_W-1:0];
    sat_d = sq_q[NSTG][SAT_QB-1] ? SAT_W'(SAT_LIMIT) : sq_q[NSTG][SAT_W-1:0];
    if (cls_q[NSTG].flat) begin
      hue_d = '0;
      sat_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= hi_q[NSTG];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (hue_q <= HUE_W'(HUE_LIMIT)))
    else $error("hue beyond limit");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bright_q == '0) |-> (hue_q == '0 && sat_q == '0))
    else $error("black pixel with non-zero hue or saturation");

  a_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v_q[NSTG]) |=> out_valid_q)
    else $error("finished beat lost at output register");

endmodule

[bench/rgb_to_hsv_pixel_test.sv]
// Self-checking bench for the RGB to HSV pixel converter.
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_test import rhp_pkg::*;;

  localparam int CB = 8;
  localparam int N_RANDOM = 1400;
  localparam int DRAIN_CYCLES = 60;
  localparam int DRAIN_LIMIT = 4000;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [CB-1:0]    bright;
  } hsv_t;

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready_o;
  logic [CB-1:0] red_i = '0;
  logic [CB-1:0] green_i = '0;
  logic [CB-1:0] blue_i = '0;
  logic          out_valid_o;
  logic          out_ready = 1'b0;
  logic [HUE_W-1:0] hue_o;
  logic [SAT_W-1:0] saturation_o;
  logic [CB-1:0]    brightness_o;

  rgb_t pixel_q[$];
  hsv_t hsv_q[$];
  int   errors = 0;
  int   in_gap = 0;
  int   out_stall = 0;
  logic in_idle = 1'b1;
  logic out_idle = 1'b1;

  rgb_to_hsv_pixel #(.CHANNEL_BITS(CB)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

  function automatic hsv_t hsv_of(input rgb_t px);
    int r, g, b, hi, lo, diff, hue, sat;
    hsv_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    diff = hi - lo;
    hue = 0;
    sat = 0;
    if (hi != 0 && diff != 0) begin
      sat = (diff << SAT_SHIFT) / hi;
      if (sat > SAT_LIMIT) sat = SAT_LIMIT;
      // signed int division truncates toward zero
      if (hi == r) begin
        hue = (g - b) * HUE_SECTOR / diff;
      end else if (hi == g) begin
        hue = (b - r) * HUE_SECTOR / diff + HUE_OFS_G;
      end else begin
        hue = (r - g) * HUE_SECTOR / diff + HUE_OFS_B;
      end
      if (hue < 0) hue += HUE_FULL;
      if (hue > HUE_LIMIT) hue = HUE_LIMIT;
    end
    res.hue = HUE_W'(hue);
    res.sat = SAT_W'(sat);
    res.bright = CB'(hi);
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("rgb_to_hsv_pixel_test: done, errors");
    $finish;
  end

  // Driver: one pixel per beat, a random gap after each one in gappy stretches
  always @(posedge clk_i or negedge rst_ni) begin : driver
    rgb_t px;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        hsv_q.push_back(hsv_of(rgb_t'{red_i, green_i, blue_i}));
      end
      if (!in_valid || in_ready_o) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pixel_q.size() != 0) begin
          px = pixel_q.pop_front();
          in_valid <= 1'b1;
          red_i <= px.red;
          green_i <= px.green;
          blue_i <= px.blue;
          in_gap <= in_idle ? int'($urandom_range(0, 4)) : 0;
          // flip between gappy and back-to-back stretches now and then
          if ($urandom_range(0, 39) == 0) in_idle <= !in_idle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat, then in stalling stretches may stall for a random count
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    hsv_t want;
    int   draw;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid_o && out_ready) begin
      if (hsv_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual hue=%0d sat=%0d val=%0d",
                 $time, hue_o, saturation_o, brightness_o);
        errors = errors + 1;
      end else begin
        want = hsv_q.pop_front();
        if (hue_o !== want.hue) begin
          $display("%0t: hue mismatch, expected %0d, actual %0d", $time, want.hue, hue_o);
          errors = errors + 1;
        end
        if (saturation_o !== want.sat) begin
          $display("%0t: saturation mismatch, expected %0d, actual %0d",
                   $time, want.sat, saturation_o);
          errors = errors + 1;
        end
        if (brightness_o !== want.bright) begin
          $display("%0t: brightness mismatch, expected %0d, actual %0d",
                   $time, want.bright, brightness_o);
          errors = errors + 1;
        end
      end
      draw = out_idle ? int'($urandom_range(0, 4)) : 0;
      if ($urandom_range(0, 39) == 0) out_idle <= !out_idle;
      out_stall <= draw;
      if (draw != 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (out_stall <= 1) begin
        out_ready <= 1'b1;
        out_stall <= 0;
      end else begin
        out_stall <= out_stall - 1;
      end
    end
  end

  initial begin : stimulus
    rgb_t px;
    int   n, v, a, c, sel, k;
    // black, white, greys
    pixel_q.push_back(rgb_t'{8'd0, 8'd0, 8'd0});
    pixel_q.push_back(rgb_t'{8'd255, 8'd255, 8'd255});
    pixel_q.push_back(rgb_t'{8'd1, 8'd1, 8'd1});
    pixel_q.push_back(rgb_t'{8'd128, 8'd128, 8'd128});
    // primaries: min zero so saturation clamps
    pixel_q.push_back(rgb_t'{8'd255, 8'd0, 8'd0});
    pixel_q.push_back(rgb_t'{8'd0, 8'd255, 8'd0});
    pixel_q.push_back(rgb_t'{8'd0, 8'd0, 8'd255});
    pixel_q.push_back(rgb_t'{8'd1, 8'd0, 8'd0});
    // ties for the maximum
    pixel_q.push_back(rgb_t'{8'd255, 8'd255, 8'd0});
    pixel_q.push_back(rgb_t'{8'd0, 8'd255, 8'd255});
    pixel_q.push_back(rgb_t'{8'd255, 8'd0, 8'd255});
    pixel_q.push_back(rgb_t'{8'd200, 8'd200, 8'd17});
    pixel_q.push_back(rgb_t'{8'd17, 8'd200, 8'd200});
    pixel_q.push_back(rgb_t'{8'd200, 8'd17, 8'd200});
    // red sector with negative difference wraps round, followed by other edge cases
    pixel_q.push_back(rgb_t'{8'd255, 8'd0, 8'd10});
    pixel_q.push_back(rgb_t'{8'd255, 8'd0, 8'd254});
    pixel_q.push_back(rgb_t'{8'd255, 8'd254, 8'd254});
    pixel_q.push_back(rgb_t'{8'd254, 8'd255, 8'd254});
    pixel_q.push_back(rgb_t'{8'd254, 8'd254, 8'd255});
    pixel_q.push_back(rgb_t'{8'd255, 8'd1, 8'd0});
    pixel_q.push_back(rgb_t'{8'd1, 8'd0, 8'd1});
    pixel_q.push_back(rgb_t'{8'd0, 8'd1, 8'd1});
    pixel_q.push_back(rgb_t'{8'd170, 8'd85, 8'd255});
    pixel_q.push_back(rgb_t'{8'd85, 8'd170, 8'd0});

    for (n = 0; n < N_RANDOM; n++) begin
      v = $urandom_range(0, 255);
      a = $urandom_range(0, v);
      c = $urandom_range(0, v);
      case ($urandom_range(0, 9))
        5: px = rgb_t'{CB'(v), CB'(v), CB'(v)};
        6: begin
          case ($urandom_range(0, 2))
            0: px = rgb_t'{CB'(v), CB'(v), CB'(a)};
            1: px = rgb_t'{CB'(a), CB'(v), CB'(v)};
            default: px = rgb_t'{CB'(v), CB'(a), CB'(v)};
          endcase
        end
        7: begin
          px = rgb_t'{CB'(v), CB'(a), CB'(c)};
          k = $urandom_range(0, 2);
          if (k == 0) px.red = '0;
          else if (k == 1) px.green = '0;
          else px.blue = '0;
        end
        8: begin
          // channels drawn from the corners 0, 1, 254, 255
          sel = $urandom_range(0, 3);
          px.red = CB'((sel >= 2 ? 254 : 0) + (sel % 2));
          sel = $urandom_range(0, 3);
          px.green = CB'((sel >= 2 ? 254 : 0) + (sel % 2));
          sel = $urandom_range(0, 3);
          px.blue = CB'((sel >= 2 ? 254 : 0) + (sel % 2));
        end
        9: begin
          // small spread around the maximum
          px.red = CB'(v - $urandom_range(0, v < 2 ? v : 2));
          px.green = CB'(v - $urandom_range(0, v < 2 ? v : 2));
          px.blue = CB'(v - $urandom_range(0, v < 2 ? v : 2));
        end
        default: begin
          px.red = CB'($urandom_range(0, 255));
          px.green = CB'($urandom_range(0, 255));
          px.blue = CB'($urandom_range(0, 255));
        end
      endcase
      pixel_q.push_back(px);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pixel_q.size() != 0 || in_valid) @(posedge clk_i);
    for (n = 0; n < DRAIN_LIMIT && hsv_q.size() != 0; n++) @(posedge clk_i);
    if (hsv_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time, hsv_q.size());
      errors = errors + 1;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("rgb_to_hsv_pixel_test: done, clean");
    end else begin
      $display("rgb_to_hsv_pixel_test: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rhp_pkg.sv
hdl/rhp_front.sv
hdl/rhp_queue.sv
hdl/rhp_back.sv
hdl/rgb_to_hsv_pixel.sv
bench/rgb_to_hsv_pixel_test.sv
